// ----- hw/rtl/smaa_pkg.sv -----
// Shared package for the sensor moving-average alarm.
// Sizes, register codes, sequencer states, memory port structs and divide constants.
// No dependencies.
`timescale 1ns / 1ps

package smaa_pkg;

	localparam int SENSOR_SLOTS  = 8;
	localparam int WINDOW_LENGTH = 5;

	localparam int ID_W     = 16;
	localparam int TEMP_W   = 16;
	localparam int SLOT_W   = 3;
	localparam int POS_W    = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;
	localparam int ENTRIES  = SENSOR_SLOTS * WINDOW_LENGTH;
	localparam int ADDR_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W    = $clog2(WINDOW_LENGTH + 1);
	localparam int SUM_W    = TEMP_W + CNT_W;
	localparam int MAG_W    = SUM_W - 1;
	localparam int CFG_W    = 64;
	localparam int CFG_IDX_W = 2;

	// Reciprocal divide: q = (mag * ceil(2^K / n)) >> K is exact for mag < 2^MAG_W
	localparam int RCP_SHIFT = MAG_W + CNT_W;
	localparam int RCP_W     = RCP_SHIFT + 1;
	localparam int PROD_W    = MAG_W + RCP_W;

	localparam logic [RCP_W-1:0] RCP_1 = RCP_W'(2 ** RCP_SHIFT);
	localparam logic [RCP_W-1:0] RCP_2 = RCP_W'((2 ** RCP_SHIFT + 1) / 2);
	localparam logic [RCP_W-1:0] RCP_3 = RCP_W'((2 ** RCP_SHIFT + 2) / 3);
	localparam logic [RCP_W-1:0] RCP_4 = RCP_W'((2 ** RCP_SHIFT + 3) / 4);
	localparam logic [RCP_W-1:0] RCP_5 = RCP_W'((2 ** RCP_SHIFT + 4) / 5);

	localparam logic [CFG_W-1:0] IDS_LO_RESET = 64'h0031_0025_0015_000F;
	localparam logic [CFG_W-1:0] IDS_HI_RESET = 64'h008E_0084_0081_0070;
	localparam logic signed [TEMP_W-1:0] MAX_T_RESET = 16'sd3200;
	localparam logic signed [TEMP_W-1:0] MIN_T_RESET = 16'sd1920;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IDS_LO = 2'd0,
		REG_IDS_HI = 2'd1,
		REG_MAX_T  = 2'd2,
		REG_MIN_T  = 2'd3
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_LAST,
		ST_DIV,
		ST_FIN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [TEMP_W-1:0] data;
	} ring_wr_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
	} ring_rd_t;

	function automatic logic [RCP_W-1:0] recip(input logic [CNT_W-1:0] n);
		logic [RCP_W-1:0] r;
		case (n)
			CNT_W'(1): r = RCP_1;
			CNT_W'(2): r = RCP_2;
			CNT_W'(3): r = RCP_3;
			CNT_W'(4): r = RCP_4;
			CNT_W'(5): r = RCP_5;
			default:   r = '0;
		endcase
		return r;
	endfunction

endpackage

// ----- hw/rtl/sensor_moving_average_alarm.sv -----
// Sensor moving-average alarm: top level with id match, ring sequencer, divide and alarm.
// Unknown id: straight to the result. Known id: ring read, divide and alarm; one item at a time,
// set by the single ring read port (one sample per cycle) and the shared accumulator.
// Reset (arst_n, async, active low) restores ids and thresholds and clears rings and positions.
// Depends on smaa_pkg and smaa_ring_store.
`timescale 1ns / 1ps

module sensor_moving_average_alarm (
	input  logic                              clk,
	input  logic                              arst_n,
	// input beat
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [31:0]                       s_tdata,  // sensor_number[15:0], temperature[31:16]
	// result beat
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [23:0]                       m_tdata,  // slot_index[2:0], average[18:3],
	                                                    // too_hot[19], too_cold[20], zero pad
	output logic                              m_tuser,  // known_sensor[0]
	// configuration writes
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [smaa_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [smaa_pkg::CFG_W-1:0]        cfg_data
);
	import smaa_pkg::*;

	// ---------------------------------------------------------------- config
	logic [CFG_W-1:0]         ids_lo_q;
	logic [CFG_W-1:0]         ids_hi_q;
	logic signed [TEMP_W-1:0] max_t_q;
	logic signed [TEMP_W-1:0] min_t_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ids_lo_q <= IDS_LO_RESET;
			ids_hi_q <= IDS_HI_RESET;
			max_t_q  <= MAX_T_RESET;
			min_t_q  <= MIN_T_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_IDS_LO: ids_lo_q <= cfg_data;
				REG_IDS_HI: ids_hi_q <= cfg_data;
				REG_MAX_T:  max_t_q  <= cfg_data[TEMP_W-1:0];
				REG_MIN_T:  min_t_q  <= cfg_data[TEMP_W-1:0];
				default:    ;
			endcase
		end
	end

	// ---------------------------------------------------------------- input fields
	logic [ID_W-1:0]   in_id;
	logic [TEMP_W-1:0] in_temp;
	logic              in_beat;

	assign in_id   = s_tdata[ID_W-1:0];
	assign in_temp = s_tdata[ID_W +: TEMP_W];
	assign in_beat = s_tvalid && s_tready;

	// ---------------------------------------------------------------- id match
	// Lowest matching slot wins, so scan from the top down.
	logic [ID_W*SENSOR_SLOTS-1:0] ids_all;
	logic                         hit;
	logic [SLOT_W-1:0]            hit_slot;

	assign ids_all = {ids_hi_q, ids_lo_q};

	always_comb begin
		hit      = 1'b0;
		hit_slot = '0;
		for (int s = SENSOR_SLOTS - 1; s >= 0; s--) begin
			if (ids_all[s*ID_W +: ID_W] == in_id) begin
				hit      = 1'b1;
				hit_slot = SLOT_W'(s);
			end
		end
	end

	// ---------------------------------------------------------------- write positions
	logic [POS_W-1:0]  wpos_q [SENSOR_SLOTS];
	logic [POS_W-1:0]  hit_pos;
	logic [ADDR_W-1:0] hit_base;

	assign hit_pos  = wpos_q[hit_slot];
	assign hit_base = ADDR_W'(hit_slot) * ADDR_W'(WINDOW_LENGTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < SENSOR_SLOTS; s++) begin
				wpos_q[s] <= '0;
			end
		end else if (in_beat && hit) begin
			if (hit_pos == POS_W'(WINDOW_LENGTH - 1)) begin
				wpos_q[hit_slot] <= '0;
			end else begin
				wpos_q[hit_slot] <= hit_pos + POS_W'(1);
			end
		end
	end

	// ---------------------------------------------------------------- sequencer
	state_t state_q, state_d;
	logic   rd_en;
	logic   out_load;
	logic   rd_last;

	logic [POS_W-1:0]  idx_q;
	logic [ADDR_W-1:0] base_q;
	logic [SLOT_W-1:0] slot_q;
	logic              found_q;
	logic              rd_pend_q;

	assign rd_last = (idx_q == POS_W'(WINDOW_LENGTH - 1));

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_beat) state_d = hit ? ST_READ : ST_DONE;
			ST_READ: if (rd_last) state_d = ST_LAST;
			ST_LAST: state_d = ST_DIV;
			ST_DIV:  state_d = ST_FIN;
			ST_FIN:  state_d = ST_DONE;
			ST_DONE: if (out_load) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		rd_en    = 1'b0;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: s_tready = 1'b1;
			ST_READ: rd_en    = 1'b1;
			ST_DONE: out_load = !m_tvalid || m_tready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			idx_q     <= '0;
			found_q   <= 1'b0;
			rd_pend_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_pend_q <= rd_en;
			if (in_beat) begin
				idx_q   <= '0;
				found_q <= hit;
			end else if (rd_en) begin
				idx_q <= idx_q + POS_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			base_q <= hit_base;
			slot_q <= hit ? hit_slot : '0;
		end
	end

	// ---------------------------------------------------------------- ring store
	ring_wr_t          ring_wr;
	ring_rd_t          ring_rd;
	logic [TEMP_W-1:0] ring_data;

	assign ring_wr.en   = in_beat && hit;
	assign ring_wr.addr = hit_base + ADDR_W'(hit_pos);
	assign ring_wr.data = in_temp;
	assign ring_rd.en   = rd_en;
	assign ring_rd.addr = base_q + ADDR_W'(idx_q);

	smaa_ring_store u_ring (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (ring_wr),
		.rd      (ring_rd),
		.rd_data (ring_data)
	);

	// ---------------------------------------------------------------- accumulate
	// One sample per cycle through the shared adder; zero entries are skipped.
	logic signed [SUM_W-1:0] acc_q;
	logic [CNT_W-1:0]        cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			cnt_q <= '0;
		end else if (in_beat) begin
			acc_q <= '0;
			cnt_q <= '0;
		end else if (rd_pend_q && (ring_data != '0)) begin
			acc_q <= acc_q + {{CNT_W{ring_data[TEMP_W-1]}}, ring_data};
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	// ---------------------------------------------------------------- divide
	// Magnitude times reciprocal of the count; the sign goes back on afterwards,
	// which gives truncation toward zero.
	logic [SUM_W-1:0]  acc_neg;
	logic [MAG_W-1:0]  mag;
	logic [PROD_W-1:0] prod;
	logic [MAG_W-1:0]  quo_s1;
	logic              neg_s1;

	assign acc_neg = -acc_q;
	assign mag     = acc_q[SUM_W-1] ? acc_neg[MAG_W-1:0] : acc_q[MAG_W-1:0];
	assign prod    = PROD_W'(mag) * PROD_W'(recip(cnt_q));

	always_ff @(posedge clk) begin
		if (state_q == ST_DIV) begin
			quo_s1 <= prod[RCP_SHIFT +: MAG_W];
			neg_s1 <= acc_q[SUM_W-1];
		end
	end

	// ---------------------------------------------------------------- alarm
	logic [MAG_W-1:0]         quo_neg;
	logic signed [TEMP_W-1:0] avg_w;
	logic signed [TEMP_W-1:0] avg_q;
	logic                     hot_q;
	logic                     cold_q;

	assign quo_neg = -quo_s1;
	assign avg_w   = (cnt_q == '0) ? '0 :
	                 (neg_s1 ? quo_neg[TEMP_W-1:0] : quo_s1[TEMP_W-1:0]);

	always_ff @(posedge clk) begin
		if (in_beat) begin
			avg_q  <= '0;
			hot_q  <= 1'b0;
			cold_q <= 1'b0;
		end else if (state_q == ST_FIN) begin
			avg_q  <= avg_w;
			hot_q  <= (cnt_q != '0) && (avg_w > max_t_q);
			cold_q <= (cnt_q != '0) && (avg_w < min_t_q);
		end
	end

	// ---------------------------------------------------------------- result register
	logic        out_valid_q;
	logic [23:0] out_data_q;
	logic        out_known_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q  <= {3'b000, cold_q, hot_q, avg_q, slot_q};
			out_known_q <= found_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_known_q;

	// ---------------------------------------------------------------- checks
`ifndef SYNTHESIS
	a_unknown_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (m_tdata == '0))
		else $error("unknown sensor result carries nonzero fields");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(WINDOW_LENGTH))
		else $error("nonzero sample count beyond window");

	a_read_known: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |-> found_q)
		else $error("ring read for unknown sensor");

	a_busy_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input taken again before result formed");
`endif

endmodule

// ----- hw/rtl/smaa_ring_store.sv -----
// Sample rings for all sensor slots: one write port, one registered read port.
// Per-entry valid bits make never-written entries read as zero after reset. Uses smaa_pkg.
`timescale 1ns / 1ps

module smaa_ring_store (
	input  logic                             clk,
	input  logic                             arst_n,
	input  smaa_pkg::ring_wr_t               wr,
	input  smaa_pkg::ring_rd_t               rd,
	output logic [smaa_pkg::TEMP_W-1:0]      rd_data
);
	import smaa_pkg::*;

	logic [TEMP_W-1:0]  mem_q [ENTRIES];
	logic [ENTRIES-1:0] valid_q;
	logic [TEMP_W-1:0]  rd_raw_q;
	logic               rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
		if (rd.en) begin
			rd_raw_q <= mem_q[rd.addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr.en) begin
				valid_q[wr.addr] <= 1'b1;
			end
			if (rd.en) begin
				rd_vld_q <= valid_q[rd.addr];
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_raw_q : '0;

endmodule
